FILE: src/value_stack_with_remove_macros.svh
// Assertion macros shared by the value stack modules.
`ifndef VALUE_STACK_WITH_REMOVE_MACROS_SVH
`define VALUE_STACK_WITH_REMOVE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/vsr_pkg.sv
// Shared constants, types and cell commands for the value stack.
package vsr_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int REQ_W      = 3;
  localparam int POS_W      = 7;
  localparam int STAT_W     = 3;
  localparam int EXT_W      = POS_W + 1;

  // Stream widths: fields packed from the lowest bit, padded to whole bytes.
  localparam int IN_BITS     = DATA_WIDTH + POS_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = DATA_WIDTH + CNT_W + CNT_W + STAT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_GET    = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_UNIQ   = 3'd4
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_EMPTY   = 3'd2,
    STAT_RANGE   = 3'd3,
    STAT_MISSING = 3'd4
  } status_e;

  // What every cell of the ring does in a cycle.
  typedef enum logic [2:0] {
    OP_HOLD = 3'd0,
    OP_PUSH = 3'd1,
    OP_POP  = 3'd2,
    OP_ROT  = 3'd3,
    OP_INIT = 3'd4,
    OP_SORT = 3'd5,
    OP_DROP = 3'd6
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAP,
    ST_DROP,
    ST_SORT
  } state_e;

  typedef enum logic [1:0] {
    LAP_GET,
    LAP_FIND,
    LAP_MARK,
    LAP_COUNT
  } lap_e;

  // Command broadcast from the controller to all cells.
  typedef struct packed {
    cell_op_e         op;
    logic [CNT_W-1:0] thr;      // lowest cell index that may be marked
    logic             mark_en;  // the head word is a live key this step
    logic             parity;   // pair parity of the sorting round
    logic [IDX_W-1:0] drop_at;  // first cell that closes the gap
    logic [CNT_W-1:0] count;    // fill count, for flag set-up
  } cell_cmd_t;

endpackage

FILE: src/value_stack_with_remove.sv
// Top level of the value stack: the controller and the ring of storage cells.
//
//   Channel | Direction | Handshake       | Payload
//   s_axis  | in        | tvalid / tready | tdata: data_value, position; tuser: req_type
//   m_axis  | out       | tvalid / tready | tdata: read_value, slot, entry_count, status
//
// Push, pop, unused codes and rejected requests give their result in the cycle
// after acceptance. Get first makes one lap of the cell ring past the head cell.
// Remove makes a lap to find the key and, when it is found, a drop step that closes
// the gap. Uniq makes a marking lap, a counting lap and odd-even sorting rounds.
// One request is in work at a time; the next is taken once the controller is idle
// and the result register is empty or being emptied. Reset clears the control
// state, the fill count and the result valid flag; the cells need no clearing.
module value_stack_with_remove (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [31:0] data_value, [38:32] position, [39] zero
  input  logic [vsr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [2:0] req_type
  input  logic [vsr_pkg::REQ_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] read_value, [38:32] slot, [45:39] entry_count, [48:46] status, [55:49] zero
  output logic [vsr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import vsr_pkg::*;

  cell_cmd_t             cmd;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic                  cell_flag [DEPTH];

  // Request sequencing and the result register.
  vsr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .head_data_i   (cell_data[0]),
    .head_flag_i   (cell_flag[0]),
    .cmd_o         (cmd)
  );

  // Ring of cells: cell 0 holds the top, the last cell wraps to cell 0.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic                  left_flag;

    if (i == 0) begin : g_head
      assign left_data = s_axis_tdata[DATA_WIDTH-1:0];
      assign left_flag = 1'b0;
    end else begin : g_body
      assign left_data = cell_data[i-1];
      assign left_flag = cell_flag[i-1];
    end

    vsr_cell u_cell (
      .clk_i        (clk_i),
      .idx_i        (IDX_W'(i)),
      .cmd_i        (cmd),
      .key_i        (cell_data[0]),
      .left_data_i  (left_data),
      .left_flag_i  (left_flag),
      .right_data_i (cell_data[(i + 1) % DEPTH]),
      .right_flag_i (cell_flag[(i + 1) % DEPTH]),
      .data_o       (cell_data[i]),
      .flag_o       (cell_flag[i])
    );
  end

endmodule

FILE: src/vsr_cell.sv
// One storage cell of the stack ring: a word, a hole flag and the local step rules.
module vsr_cell (
  input  logic                           clk_i,
  input  logic [vsr_pkg::IDX_W-1:0]      idx_i,
  input  vsr_pkg::cell_cmd_t             cmd_i,
  input  logic [vsr_pkg::DATA_WIDTH-1:0] key_i,
  input  logic [vsr_pkg::DATA_WIDTH-1:0] left_data_i,
  input  logic                           left_flag_i,
  input  logic [vsr_pkg::DATA_WIDTH-1:0] right_data_i,
  input  logic                           right_flag_i,
  output logic [vsr_pkg::DATA_WIDTH-1:0] data_o,
  output logic                           flag_o
);
  import vsr_pkg::*;

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  flag_q, flag_d;
  logic                  mark;
  logic                  is_left, is_right;

  // A later copy of the key sits at a lower cell index: mark it as a hole.
  assign mark   = cmd_i.mark_en && (data_q == key_i) && (CNT_W'(idx_i) >= cmd_i.thr);
  assign data_o = data_q;
  assign flag_o = flag_q | mark;

  // Pair roles in the odd-even sorting round.
  assign is_left  = (idx_i[0] == cmd_i.parity) && (idx_i != IDX_W'(DEPTH - 1));
  assign is_right = (idx_i[0] != cmd_i.parity) && (idx_i != '0);

  // Next word and flag for the broadcast command.
  always_comb begin
    data_d = data_q;
    flag_d = flag_q;
    case (cmd_i.op)
      OP_PUSH: begin
        data_d = left_data_i;
        flag_d = left_flag_i;
      end
      OP_POP: begin
        data_d = right_data_i;
        flag_d = right_flag_i;
      end
      OP_ROT: begin
        data_d = right_data_i;
        flag_d = right_flag_i;
      end
      OP_INIT: begin
        flag_d = (CNT_W'(idx_i) >= cmd_i.count);
      end
      OP_SORT: begin
        if (is_left && flag_q && !right_flag_i) begin
          data_d = right_data_i;
          flag_d = right_flag_i;
        end else if (is_right && left_flag_i && !flag_q) begin
          data_d = left_data_i;
          flag_d = left_flag_i;
        end
      end
      OP_DROP: begin
        if (idx_i >= cmd_i.drop_at) begin
          data_d = right_data_i;
          flag_d = right_flag_i;
        end
      end
      default: begin
        data_d = data_q;
        flag_d = flag_q;
      end
    endcase
  end

  // Cell storage holds the word and its hole flag, with no reset.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    flag_q <= flag_d;
  end

endmodule

FILE: src/vsr_ctrl.sv
// Request sequencer of the value stack: decodes requests, steps the ring, holds the result.
module vsr_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [vsr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [vsr_pkg::REQ_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [vsr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic [vsr_pkg::DATA_WIDTH-1:0]  head_data_i,
  input  logic                            head_flag_i,
  output vsr_pkg::cell_cmd_t              cmd_o
);
  import vsr_pkg::*;

  `include "value_stack_with_remove_macros.svh"

  state_e                state_q, state_d;
  lap_e                  lap_q, lap_d;
  logic [IDX_W-1:0]      step_q, step_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      kept_q, kept_d;
  logic [DATA_WIDTH-1:0] key_q, key_d;
  logic [DATA_WIDTH-1:0] rd_q, rd_d;
  logic [IDX_W-1:0]      tgt_q, tgt_d;
  logic                  found_q, found_d;
  logic [IDX_W-1:0]      hit_q, hit_d;

  logic                  out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0] out_read_q, out_read_d;
  logic [CNT_W-1:0]      out_slot_q, out_slot_d;
  logic [CNT_W-1:0]      out_count_q, out_count_d;
  status_e               out_stat_q, out_stat_d;

  logic                  accept;
  req_e                  req;
  logic [DATA_WIDTH-1:0] in_value;
  logic [POS_W-1:0]      in_pos;
  logic [EXT_W-1:0]      pos_ext, cnt_ext, neg_sum, tgt_up;
  logic                  pos_ok, neg_ok, last_step, step_live;

  // Field unpacking and index range decode for get.
  assign req      = req_e'(s_axis_tuser);
  assign in_value = s_axis_tdata[DATA_WIDTH-1:0];
  assign in_pos   = s_axis_tdata[DATA_WIDTH +: POS_W];
  assign pos_ext  = {in_pos[POS_W-1], in_pos};
  assign cnt_ext  = EXT_W'(count_q);
  assign neg_sum  = cnt_ext + pos_ext;
  assign tgt_up   = cnt_ext - pos_ext - EXT_W'(1);
  assign pos_ok   = !in_pos[POS_W-1] && (pos_ext < cnt_ext);
  assign neg_ok   = in_pos[POS_W-1] && !neg_sum[EXT_W-1];

  assign last_step = (step_q == IDX_W'(DEPTH - 1));
  assign step_live = (CNT_W'(step_q) < count_q);

  // Only an idle controller with a free result register takes a request.
  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_stat_q, out_count_q, out_slot_q, out_read_q};

  // Next state, ring command and result.
  always_comb begin
    state_d     = state_q;
    lap_d       = lap_q;
    step_d      = step_q;
    count_d     = count_q;
    kept_d      = kept_q;
    key_d       = key_q;
    rd_d        = rd_q;
    tgt_d       = tgt_q;
    found_d     = found_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_read_d  = out_read_q;
    out_slot_d  = out_slot_q;
    out_count_d = out_count_q;
    out_stat_d  = out_stat_q;
    cmd_o       = '0;
    cmd_o.op    = OP_HOLD;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_read_d  = '0;
          out_slot_d  = '0;
          out_count_d = count_q;
          out_stat_d  = STAT_OK;
          step_d      = '0;
          case (req)
            REQ_PUSH: begin
              out_valid_d = 1'b1;
              if (count_q == CNT_W'(DEPTH)) begin
                out_stat_d = STAT_FULL;
              end else begin
                cmd_o.op    = OP_PUSH;
                out_slot_d  = count_q;
                count_d     = count_q + CNT_W'(1);
                out_count_d = count_d;
              end
            end
            REQ_POP: begin
              out_valid_d = 1'b1;
              if (count_q == '0) begin
                out_stat_d = STAT_EMPTY;
              end else begin
                cmd_o.op    = OP_POP;
                out_read_d  = head_data_i;
                count_d     = count_q - CNT_W'(1);
                out_count_d = count_d;
              end
            end
            REQ_GET: begin
              if (pos_ok || neg_ok) begin
                tgt_d   = pos_ok ? IDX_W'(tgt_up) : IDX_W'(~pos_ext);
                rd_d    = '0;
                lap_d   = LAP_GET;
                state_d = ST_LAP;
              end else begin
                out_valid_d = 1'b1;
                out_stat_d  = STAT_RANGE;
              end
            end
            REQ_REMOVE: begin
              if (count_q == '0) begin
                out_valid_d = 1'b1;
                out_stat_d  = STAT_MISSING;
              end else begin
                key_d   = in_value;
                found_d = 1'b0;
                hit_d   = '0;
                lap_d   = LAP_FIND;
                state_d = ST_LAP;
              end
            end
            REQ_UNIQ: begin
              cmd_o.op    = OP_INIT;
              cmd_o.count = count_q;
              kept_d      = '0;
              lap_d       = LAP_MARK;
              state_d     = ST_LAP;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end

      ST_LAP: begin
        cmd_o.op = OP_ROT;
        step_d   = last_step ? '0 : step_q + IDX_W'(1);
        case (lap_q)
          LAP_GET: begin
            if (step_q == tgt_q) begin
              rd_d = head_data_i;
            end
            if (last_step) begin
              out_valid_d = 1'b1;
              out_read_d  = rd_d;
              out_slot_d  = '0;
              out_count_d = count_q;
              out_stat_d  = STAT_OK;
              state_d     = ST_IDLE;
            end
          end
          LAP_FIND: begin
            // The topmost match is the first live word to reach the head.
            if (step_live && !found_q && (head_data_i == key_q)) begin
              found_d = 1'b1;
              hit_d   = step_q;
            end
            if (last_step) begin
              if (found_d) begin
                state_d = ST_DROP;
              end else begin
                out_valid_d = 1'b1;
                out_read_d  = '0;
                out_slot_d  = '0;
                out_count_d = count_q;
                out_stat_d  = STAT_MISSING;
                state_d     = ST_IDLE;
              end
            end
          end
          LAP_MARK: begin
            cmd_o.mark_en = step_live;
            cmd_o.thr     = CNT_W'(DEPTH) - CNT_W'(step_q);
            if (last_step) begin
              lap_d = LAP_COUNT;
            end
          end
          LAP_COUNT: begin
            if (!head_flag_i) begin
              kept_d = kept_q + CNT_W'(1);
            end
            if (last_step) begin
              state_d = ST_SORT;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_DROP: begin
        cmd_o.op      = OP_DROP;
        cmd_o.drop_at = hit_q;
        count_d       = count_q - CNT_W'(1);
        out_valid_d   = 1'b1;
        out_read_d    = '0;
        out_slot_d    = '0;
        out_count_d   = count_d;
        out_stat_d    = STAT_OK;
        state_d       = ST_IDLE;
      end

      ST_SORT: begin
        // Odd-even rounds push the holes past the kept words.
        cmd_o.op     = OP_SORT;
        cmd_o.parity = step_q[0];
        step_d       = last_step ? '0 : step_q + IDX_W'(1);
        if (last_step) begin
          count_d     = kept_q;
          out_valid_d = 1'b1;
          out_read_d  = '0;
          out_slot_d  = '0;
          out_count_d = kept_q;
          out_stat_d  = STAT_OK;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lap_q       <= LAP_GET;
      step_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lap_q       <= lap_d;
      step_q      <= step_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk_i) begin
    kept_q      <= kept_d;
    key_q       <= key_d;
    rd_q        <= rd_d;
    tgt_q       <= tgt_d;
    found_q     <= found_d;
    hit_q       <= hit_d;
    out_read_q  <= out_read_d;
    out_slot_q  <= out_slot_d;
    out_count_q <= out_count_d;
    out_stat_q  <= out_stat_d;
  end

  `VSR_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(DEPTH),
                  "fill count beyond depth")
  `VSR_ASSERT_NOW(a_busy_blocks, clk_i, rst_ni, state_q != ST_IDLE,
                  !s_axis_tready && !out_valid_q,
                  "request taken or result pending while busy")
  `VSR_ASSERT_NEXT(a_push_grows, clk_i, rst_ni,
                   accept && (req == REQ_PUSH) && (count_q != CNT_W'(DEPTH)),
                   count_q == $past(count_q) + CNT_W'(1), "push did not grow the stack")
  `VSR_ASSERT_NEXT(a_drop_shrinks, clk_i, rst_ni, state_q == ST_DROP,
                   out_valid_q && (count_q == $past(count_q) - CNT_W'(1)),
                   "remove did not shrink the stack")

endmodule

FILE: sim/value_stack_with_remove_test.sv
// Self-checking stream testbench for the value stack with search and remove.
module value_stack_with_remove_test;
  import vsr_pkg::*;

  localparam int ITEM_TARGET    = 550;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SINK_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 3 * DEPTH + 8;

  localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_CODE_MAX     = 3'd7;

  // One result as it sits in the low bits of m_axis_tdata.
  typedef struct packed {
    logic [STAT_W-1:0]     status;
    logic [CNT_W-1:0]      entry_count;
    logic [CNT_W-1:0]      slot;
    logic [DATA_WIDTH-1:0] read_value;
  } stack_reply_t;

  typedef enum int {
    RUN_GROW,
    RUN_SHRINK,
    RUN_MIXED
  } run_kind_e;

  // Mirror of the stack and the queue of replies still owed by the block.
  class stack_scoreboard;
    logic [DATA_WIDTH-1:0] words [DEPTH];
    int                    count;
    stack_reply_t          owed_replies [$];
    int                    error_count;

    function new();
      count       = 0;
      error_count = 0;
    endfunction

    function int pending();
      return owed_replies.size();
    endfunction

    // Apply one accepted request to the mirror and queue the reply it owes.
    function void note_request(logic [REQ_W-1:0] req, logic [DATA_WIDTH-1:0] value,
                               logic [POS_W-1:0] pos);
      stack_reply_t reply;
      int           idx;
      int           hit;
      int           kept;
      bit           seen;
      reply = '0;
      case (req)
        REQ_PUSH: begin
          if (count >= DEPTH) begin
            reply.status = STAT_FULL;
          end else begin
            reply.slot   = CNT_W'(count);
            words[count] = value;
            count++;
          end
        end
        REQ_POP: begin
          if (count == 0) begin
            reply.status = STAT_EMPTY;
          end else begin
            count--;
            reply.read_value = words[count];
          end
        end
        REQ_GET: begin
          idx = $signed(pos);
          if (idx >= 0 && idx < count) reply.read_value = words[idx];
          else if (idx < 0 && -idx <= count) reply.read_value = words[count + idx];
          else reply.status = STAT_RANGE;
        end
        REQ_REMOVE: begin
          // The topmost match goes; everything above it moves down one place.
          hit = -1;
          for (int i = count - 1; i >= 0; i--) begin
            if (words[i] == value) begin
              hit = i;
              break;
            end
          end
          if (hit < 0) begin
            reply.status = STAT_MISSING;
          end else begin
            for (int k = hit + 1; k < count; k++) words[k-1] = words[k];
            count--;
          end
        end
        REQ_UNIQ: begin
          // First occurrences stay, in their order.
          kept = 0;
          for (int i = 0; i < count; i++) begin
            seen = 1'b0;
            for (int j = 0; j < kept; j++) if (words[j] == words[i]) seen = 1'b1;
            if (!seen) begin
              words[kept] = words[i];
              kept++;
            end
          end
          count = kept;
        end
        default: ;
      endcase
      reply.entry_count = CNT_W'(count);
      owed_replies.push_back(reply);
    endfunction

    function void compare_field(string name, logic [DATA_WIDTH-1:0] want,
                                logic [DATA_WIDTH-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        error_count++;
      end
    endfunction

    // Compare one accepted reply with the oldest one owed.
    function void check_response(logic [OUT_TDATA_W-1:0] tdata);
      stack_reply_t got;
      stack_reply_t want;
      got = stack_reply_t'(tdata[OUT_BITS-1:0]);
      if (owed_replies.size() == 0) begin
        $display("%0t: reply with none owed, expected nothing, actual %0h", $time, tdata);
        error_count++;
      end else begin
        want = owed_replies.pop_front();
        compare_field("read_value", want.read_value, got.read_value);
        compare_field("slot", DATA_WIDTH'(want.slot), DATA_WIDTH'(got.slot));
        compare_field("entry_count", DATA_WIDTH'(want.entry_count),
                      DATA_WIDTH'(got.entry_count));
        compare_field("status", DATA_WIDTH'(want.status), DATA_WIDTH'(got.status));
      end
    endfunction
  endclass

  logic                   clk_i  = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [REQ_W-1:0]       s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  stack_scoreboard sb;
  int              items_sent    = 0;
  int              idle_cycles   = 0;
  bit              steady_flow   = 1'b0;
  bit              sink_hold_off = 1'b0;

  value_stack_with_remove dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Offer one request, with an occasional gap first, and wait until it is taken.
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [DATA_WIDTH-1:0] value,
                              input logic [POS_W-1:0] pos);
    int gap;
    gap = 0;
    // A stretch of requests in the middle of the run flows with no idling on either side.
    steady_flow = (items_sent >= 150 && items_sent < 260);
    if (!steady_flow && $urandom_range(99) < 18) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({pos, value});
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(req, value, pos);
    items_sent++;
  endtask

  // Mostly a small pool so that keys repeat, sometimes a full random word.
  function automatic logic [DATA_WIDTH-1:0] pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 65) return DATA_WIDTH'($urandom_range(0, 15));
    if (roll < 75) return ~DATA_WIDTH'($urandom_range(0, 3));
    return $urandom;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_key();
    if (sb.count > 0 && $urandom_range(99) < 70)
      return sb.words[$urandom_range(0, sb.count - 1)];
    return pick_value();
  endfunction

  // An index inside the stack from either end, or any index at all.
  function automatic logic [POS_W-1:0] pick_index();
    if (sb.count == 0 || $urandom_range(99) < 25) return POS_W'($urandom_range(0, 127));
    if ($urandom_range(1)) return POS_W'($urandom_range(0, sb.count - 1));
    return POS_W'(-$urandom_range(1, sb.count));
  endfunction

  // One random request; push and pop weights steer the fill level.
  task automatic random_item(input int push_w, input int pop_w);
    int roll;
    int pick;
    roll = $urandom_range(99);
    pick = $urandom_range(99);
    if (roll < push_w) send_request(REQ_PUSH, pick_value(), POS_W'($urandom_range(0, 127)));
    else if (roll < push_w + pop_w) send_request(REQ_POP, $urandom, POS_W'($urandom));
    else if (pick < 50) send_request(REQ_GET, $urandom, pick_index());
    else if (pick < 80) send_request(REQ_REMOVE, pick_key(), POS_W'($urandom));
    else if (pick < 88) send_request(REQ_UNIQ, $urandom, POS_W'($urandom));
    else if (pick < 92)
      send_request(REQ_W'($urandom_range(REQ_UNUSED_FIRST, REQ_CODE_MAX)), $urandom,
                   POS_W'($urandom));
    else send_request(REQ_GET, $urandom, POS_W'($urandom_range(0, 127)));
  endtask

  task automatic run_sequence(input run_kind_e kind, input int push_w);
    int guard;
    guard = 0;
    case (kind)
      RUN_GROW: begin
        while (sb.count < DEPTH && guard < 300 && items_sent < ITEM_TARGET) begin
          random_item(push_w, 3);
          guard++;
        end
        repeat ($urandom_range(1, 3)) send_request(REQ_PUSH, pick_value(), POS_W'($urandom));
      end
      RUN_SHRINK: begin
        while (sb.count > 0 && guard < 300 && items_sent < ITEM_TARGET) begin
          random_item(5, 55);
          guard++;
        end
        repeat ($urandom_range(1, 2)) send_request(REQ_POP, $urandom, POS_W'($urandom));
      end
      default: repeat (25) random_item(30, 22);
    endcase
  endtask

  // Receiver: random stalls, a steady stretch, and one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk_i);
        sink_hold_off = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (steady_flow) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 18);
      end
    end
  end

  // Check every reply the block hands over.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_response(m_axis_tdata);
  end

  // End the run when neither side has moved for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("value_stack_with_remove_test: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Main sequence: reset, directed requests, random runs, drain and verdict.
  initial begin
    bit held;
    int roll;
    held          = 1'b0;
    sb            = new();
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_PUSH;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every request but push on an empty stack, including the spare codes.
    send_request(REQ_POP, '0, '0);
    send_request(REQ_GET, '0, POS_W'(0));
    send_request(REQ_GET, '0, POS_W'(-1));
    send_request(REQ_REMOVE, DATA_WIDTH'(5), '0);
    send_request(REQ_UNIQ, '0, '0);
    for (int code = REQ_UNUSED_FIRST; code <= REQ_CODE_MAX; code++)
      send_request(REQ_W'(code), $urandom, POS_W'($urandom));

    // A small stack with duplicates and both word extremes.
    send_request(REQ_PUSH, '0, '0);
    send_request(REQ_PUSH, '1, '1);
    send_request(REQ_PUSH, DATA_WIDTH'(7), '0);
    send_request(REQ_PUSH, '0, '0);
    send_request(REQ_PUSH, DATA_WIDTH'(7), '0);

    // Index edges: both ends, the range limits and just past them.
    send_request(REQ_GET, '0, POS_W'(0));
    send_request(REQ_GET, '0, POS_W'(-1));
    send_request(REQ_GET, '0, POS_W'(63));
    send_request(REQ_GET, '0, POS_W'(-64));
    send_request(REQ_GET, '0, POS_W'(5));
    send_request(REQ_GET, '0, POS_W'(-5));
    send_request(REQ_GET, '0, POS_W'(-6));

    send_request(REQ_REMOVE, DATA_WIDTH'(7), '0);
    send_request(REQ_REMOVE, DATA_WIDTH'(12345), '0);
    send_request(REQ_UNIQ, '0, '0);
    send_request(REQ_POP, '0, '0);

    // Fill to the brim and drain to nothing once for sure, then mix at random.
    run_sequence(RUN_GROW, 90);
    run_sequence(RUN_SHRINK, 0);
    while (items_sent < ITEM_TARGET) begin
      if (!held && items_sent >= 320) begin
        sink_hold_off = 1'b1;
        held          = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 30) run_sequence(RUN_GROW, 75);
      else if (roll < 60) run_sequence(RUN_SHRINK, 0);
      else run_sequence(RUN_MIXED, 0);
    end
    s_axis_tvalid <= 1'b0;
    steady_flow = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.error_count == 0) begin
      $display("value_stack_with_remove_test: done, clean");
    end else begin
      $display("value_stack_with_remove_test: done, errors");
    end
    $finish;
  end

endmodule
